>>> sv/scan_disk_scheduler_unit_defines.svh
// Assertion macros for the SCAN disk scheduler.
// Expects signals clk and rst_n in the including scope.
`ifndef SCAN_DISK_SCHEDULER_UNIT_DEFINES_SVH
`define SCAN_DISK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define SDSCH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sdsch_pkg.sv
// Shared types and constants for the SCAN disk scheduler.
// No dependencies.
`default_nettype none

package sdsch_pkg;

    localparam int TRACK_W   = 8;
    localparam int SEEK_W    = TRACK_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = TRACK_W;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_TRACK  = 2'd2;

    localparam logic [TRACK_W-1:0] TOP_RESET = 8'd199;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [TRACK_W-1:0] visit_track;
        logic               final_res;
        logic [SEEK_W-1:0]  seek_total;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } out_load_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_LO_RD,
        ST_HI_RD,
        ST_HI_CAP,
        ST_HEAD,
        ST_L1_RD,
        ST_L1_OUT,
        ST_STOP,
        ST_L2_RD,
        ST_L2_OUT
    } state_t;

endpackage

`default_nettype wire

>>> sv/scan_disk_scheduler_unit.sv
// Top level of the SCAN disk scheduler: sorted request store and sweep sequencer.
// Depends on sdsch_pkg, sdsch_ram, sdsch_out and the assertion macro header.
//
//  port group  | dir | beat
//  in_*        | in  | one request: track, last
//  out_*       | out | one visited track; final_res and seek_total on the last beat
//  cfg_*       | in  | register write: head_start, sweep_up, top_track
//
// A request shifts each larger stored entry up one place and is written into the gap.
// A last request then scans the sorted entries for the split at the head, reads the end
// entries, then emits the head, each track of the first sweep, the end stop and each
// track of the second sweep; the single store read port gives every read its own state.
// Reset clears the state, the request count and the config registers; the store needs no clearing.
// A stalled output holds the sequencer; input stall is high while not idle.
`default_nettype none

module scan_disk_scheduler_unit #(
    parameter int MAX_REQUESTS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire sdsch_pkg::in_item_t                 in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output sdsch_pkg::out_item_t                     out_data,
    input  wire logic                                cfg_we,
    input  wire logic [sdsch_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [sdsch_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

    localparam int TW    = sdsch_pkg::TRACK_W;
    localparam int SW    = sdsch_pkg::SEEK_W;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int AW    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    sdsch_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  split_reg, split_next;
    logic [TW-1:0]     val_reg, val_next;
    logic              last_reg, last_next;
    logic [TW-1:0]     lo_reg, lo_next;
    logic [SW-1:0]     seek_reg, seek_next;

    logic [TW-1:0]     head_reg;
    logic              up_reg;
    logic [TW-1:0]     top_reg;

    logic [TW-1:0]     h_sat;
    logic [TW-1:0]     trk_sat;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  cnt_dec;
    logic              in_acc;
    logic              has_room;
    logic              scan_hit;
    logic              l1_end;
    logic              l2_end;
    logic              l2_fin;
    logic              stop_fin;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [TW-1:0]     ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [TW-1:0]     ram_rdata;

    sdsch_pkg::out_load_t load;
    logic                 out_free;

    assign h_sat    = (head_reg > top_reg) ? top_reg : head_reg;
    assign trk_sat  = (in_data.track > top_reg) ? top_reg : in_data.track;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign in_stall = (state_reg != sdsch_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign has_room = (cnt_reg < CNT_W'(MAX_REQUESTS));
    assign scan_hit = up_reg ? (ram_rdata < h_sat) : (ram_rdata <= h_sat);
    assign l1_end   = up_reg ? (idx_reg == cnt_reg) : (idx_reg == '0);
    assign l2_end   = up_reg ? (idx_reg == '0) : (idx_reg == cnt_reg);
    assign l2_fin   = up_reg ? (idx_reg == CNT_W'(1)) : (idx_inc == cnt_reg);
    assign stop_fin = up_reg ? (split_reg == '0) : (split_reg == cnt_reg);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            up_reg   <= 1'b1;
            top_reg  <= sdsch_pkg::TOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                sdsch_pkg::CFG_HEAD_START: head_reg <= cfg_wdata;
                sdsch_pkg::CFG_SWEEP_UP:   up_reg   <= cfg_wdata[0];
                sdsch_pkg::CFG_TOP_TRACK:  top_reg  <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        split_next = split_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        lo_next    = lo_reg;
        seek_next  = seek_reg;
        unique case (state_reg)
            sdsch_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    val_next  = trk_sat;
                    last_next = in_data.last;
                    idx_next  = cnt_reg;
                    if (has_room)
                    begin
                        state_next = sdsch_pkg::ST_INS_RD;
                    end
                    else if (in_data.last)
                    begin
                        idx_next   = '0;
                        state_next = sdsch_pkg::ST_SCAN_RD;
                    end
                end
            end
            sdsch_pkg::ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = last_reg ? sdsch_pkg::ST_SCAN_RD : sdsch_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sdsch_pkg::ST_INS_CMP;
                end
            end
            sdsch_pkg::ST_INS_CMP:
            begin
                if (ram_rdata > val_reg)
                begin
                    idx_next   = idx_dec;
                    state_next = sdsch_pkg::ST_INS_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    idx_next   = '0;
                    state_next = last_reg ? sdsch_pkg::ST_SCAN_RD : sdsch_pkg::ST_IDLE;
                end
            end
            sdsch_pkg::ST_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    split_next = idx_reg;
                    state_next = sdsch_pkg::ST_LO_RD;
                end
                else
                begin
                    state_next = sdsch_pkg::ST_SCAN_CMP;
                end
            end
            sdsch_pkg::ST_SCAN_CMP:
            begin
                if (scan_hit)
                begin
                    idx_next   = idx_inc;
                    state_next = sdsch_pkg::ST_SCAN_RD;
                end
                else
                begin
                    split_next = idx_reg;
                    state_next = sdsch_pkg::ST_LO_RD;
                end
            end
            sdsch_pkg::ST_LO_RD:
            begin
                state_next = sdsch_pkg::ST_HI_RD;
            end
            sdsch_pkg::ST_HI_RD:
            begin
                lo_next    = ram_rdata;
                state_next = sdsch_pkg::ST_HI_CAP;
            end
            sdsch_pkg::ST_HI_CAP:
            begin
                if (up_reg)
                begin
                    seek_next = (SW'(top_reg) - SW'(h_sat))
                              + ((split_reg != '0) ? (SW'(top_reg) - SW'(lo_reg)) : '0);
                end
                else
                begin
                    seek_next = SW'(h_sat)
                              + ((split_reg != cnt_reg) ? SW'(ram_rdata) : '0);
                end
                state_next = sdsch_pkg::ST_HEAD;
            end
            sdsch_pkg::ST_HEAD:
            begin
                if (out_free)
                begin
                    idx_next   = split_reg;
                    state_next = sdsch_pkg::ST_L1_RD;
                end
            end
            sdsch_pkg::ST_L1_RD:
            begin
                state_next = l1_end ? sdsch_pkg::ST_STOP : sdsch_pkg::ST_L1_OUT;
            end
            sdsch_pkg::ST_L1_OUT:
            begin
                if (out_free)
                begin
                    idx_next   = up_reg ? idx_inc : idx_dec;
                    state_next = sdsch_pkg::ST_L1_RD;
                end
            end
            sdsch_pkg::ST_STOP:
            begin
                if (out_free)
                begin
                    idx_next = split_reg;
                    if (stop_fin)
                    begin
                        cnt_next   = '0;
                        state_next = sdsch_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = sdsch_pkg::ST_L2_RD;
                    end
                end
            end
            sdsch_pkg::ST_L2_RD:
            begin
                if (l2_end)
                begin
                    cnt_next   = '0;
                    state_next = sdsch_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sdsch_pkg::ST_L2_OUT;
                end
            end
            sdsch_pkg::ST_L2_OUT:
            begin
                if (out_free)
                begin
                    idx_next = up_reg ? idx_dec : idx_inc;
                    if (l2_fin)
                    begin
                        cnt_next   = '0;
                        state_next = sdsch_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = sdsch_pkg::ST_L2_RD;
                    end
                end
            end
            default:
            begin
                state_next = sdsch_pkg::ST_IDLE;
            end
        endcase
    end

    // store access and result beats
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = idx_reg[AW-1:0];
        ram_wdata  = val_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[AW-1:0];
        load.valid = 1'b0;
        load.item.visit_track = ram_rdata;
        load.item.final_res   = 1'b0;
        load.item.seek_total  = '0;
        unique case (state_reg)
            sdsch_pkg::ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[AW-1:0];
                end
            end
            sdsch_pkg::ST_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = (ram_rdata > val_reg) ? ram_rdata : val_reg;
            end
            sdsch_pkg::ST_SCAN_RD:
            begin
                ram_re = (idx_reg != cnt_reg);
            end
            sdsch_pkg::ST_LO_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            sdsch_pkg::ST_HI_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = cnt_dec[AW-1:0];
            end
            sdsch_pkg::ST_HEAD:
            begin
                load.valid            = out_free;
                load.item.visit_track = h_sat;
            end
            sdsch_pkg::ST_L1_RD:
            begin
                ram_re    = !l1_end;
                ram_raddr = up_reg ? idx_reg[AW-1:0] : idx_dec[AW-1:0];
            end
            sdsch_pkg::ST_L1_OUT:
            begin
                load.valid = out_free;
            end
            sdsch_pkg::ST_STOP:
            begin
                load.valid            = out_free;
                load.item.visit_track = up_reg ? top_reg : '0;
                load.item.final_res   = stop_fin;
                load.item.seek_total  = stop_fin ? seek_reg : '0;
            end
            sdsch_pkg::ST_L2_RD:
            begin
                ram_re    = !l2_end;
                ram_raddr = up_reg ? idx_dec[AW-1:0] : idx_reg[AW-1:0];
            end
            sdsch_pkg::ST_L2_OUT:
            begin
                load.valid           = out_free;
                load.item.final_res  = l2_fin;
                load.item.seek_total = l2_fin ? seek_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdsch_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        split_reg <= split_next;
        val_reg   <= val_next;
        last_reg  <= last_next;
        lo_reg    <= lo_next;
        seek_reg  <= seek_next;
    end

    sdsch_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sdsch_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .free      (out_free)
    );

`include "scan_disk_scheduler_unit_defines.svh"

    `SDSCH_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_REQUESTS), "request count overflow")
    `SDSCH_ASSERT_NOW(a_seek_zero, out_valid && !out_data.final_res, out_data.seek_total == '0, "seek total on non-final beat")
    `SDSCH_ASSERT_NEXT(a_cnt_hold, (state_reg == sdsch_pkg::ST_IDLE) && !in_valid, $stable(cnt_reg), "request count moved while idle")
    `SDSCH_ASSERT_NOW(a_wr_phase, ram_we, (state_reg == sdsch_pkg::ST_INS_RD) || (state_reg == sdsch_pkg::ST_INS_CMP), "store written outside insertion")

endmodule

`default_nettype wire

>>> sv/sdsch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sdsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/sdsch_out.sv
// Output register of the SCAN disk scheduler: holds one result beat.
// Depends on sdsch_pkg.
`default_nettype none

module sdsch_out (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sdsch_pkg::out_load_t load,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output sdsch_pkg::out_item_t      out_data,
    output logic                      free
);

    logic                 valid_reg;
    logic                 valid_next;
    sdsch_pkg::out_item_t data_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load.valid)
        begin
            valid_next = 1'b1;
        end
        else if (free)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            data_reg <= load.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire
